// ===== sv/ripemd160_hash_assert.svh =====
// Assertion macros for the RIPEMD-160 hash block.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef RIPEMD160_HASH_ASSERT_SVH
`define RIPEMD160_HASH_ASSERT_SVH

`ifndef SYNTHESIS
`define RMD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");
`define RMD_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("assertion failed");
`else
`define RMD_ASSERT(lbl, prop)
`define RMD_ASSERT_NEXT(lbl, pre, post)
`endif

`endif

// ===== sv/rmd160_pkg.sv =====
// Shared types, constants and round functions for the RIPEMD-160 block.
// No dependencies; used by the top level.
package rmd160_pkg;

  localparam int unsigned WordW    = 32;
  localparam int unsigned BufDepth = 16;
  localparam int unsigned ChainN   = 5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_PREP,
    ST_ROUND,
    ST_FOLD,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
    logic [31:0] e;
  } line_t;

  localparam logic [31:0] IV [5] = '{
    32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
  };

  localparam logic [3:0] WORD_SEL [160] = '{
    4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
    4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15,
    4'd7, 4'd4, 4'd13, 4'd1, 4'd10, 4'd6, 4'd15, 4'd3,
    4'd12, 4'd0, 4'd9, 4'd5, 4'd2, 4'd14, 4'd11, 4'd8,
    4'd3, 4'd10, 4'd14, 4'd4, 4'd9, 4'd15, 4'd8, 4'd1,
    4'd2, 4'd7, 4'd0, 4'd6, 4'd13, 4'd11, 4'd5, 4'd12,
    4'd1, 4'd9, 4'd11, 4'd10, 4'd0, 4'd8, 4'd12, 4'd4,
    4'd13, 4'd3, 4'd7, 4'd15, 4'd14, 4'd5, 4'd6, 4'd2,
    4'd4, 4'd0, 4'd5, 4'd9, 4'd7, 4'd12, 4'd2, 4'd10,
    4'd14, 4'd1, 4'd3, 4'd8, 4'd11, 4'd6, 4'd15, 4'd13,
    4'd5, 4'd14, 4'd7, 4'd0, 4'd9, 4'd2, 4'd11, 4'd4,
    4'd13, 4'd6, 4'd15, 4'd8, 4'd1, 4'd10, 4'd3, 4'd12,
    4'd6, 4'd11, 4'd3, 4'd7, 4'd0, 4'd13, 4'd5, 4'd10,
    4'd14, 4'd15, 4'd8, 4'd12, 4'd4, 4'd9, 4'd1, 4'd2,
    4'd15, 4'd5, 4'd1, 4'd3, 4'd7, 4'd14, 4'd6, 4'd9,
    4'd11, 4'd8, 4'd12, 4'd2, 4'd10, 4'd0, 4'd4, 4'd13,
    4'd8, 4'd6, 4'd4, 4'd1, 4'd3, 4'd11, 4'd15, 4'd0,
    4'd5, 4'd12, 4'd2, 4'd13, 4'd9, 4'd7, 4'd10, 4'd14,
    4'd12, 4'd15, 4'd10, 4'd4, 4'd1, 4'd5, 4'd8, 4'd7,
    4'd6, 4'd2, 4'd13, 4'd14, 4'd0, 4'd3, 4'd9, 4'd11
  };

  localparam logic [3:0] ROT_AMT [160] = '{
    4'd11, 4'd14, 4'd15, 4'd12, 4'd5, 4'd8, 4'd7, 4'd9,
    4'd11, 4'd13, 4'd14, 4'd15, 4'd6, 4'd7, 4'd9, 4'd8,
    4'd7, 4'd6, 4'd8, 4'd13, 4'd11, 4'd9, 4'd7, 4'd15,
    4'd7, 4'd12, 4'd15, 4'd9, 4'd11, 4'd7, 4'd13, 4'd12,
    4'd11, 4'd13, 4'd6, 4'd7, 4'd14, 4'd9, 4'd13, 4'd15,
    4'd14, 4'd8, 4'd13, 4'd6, 4'd5, 4'd12, 4'd7, 4'd5,
    4'd11, 4'd12, 4'd14, 4'd15, 4'd14, 4'd15, 4'd9, 4'd8,
    4'd9, 4'd14, 4'd5, 4'd6, 4'd8, 4'd6, 4'd5, 4'd12,
    4'd9, 4'd15, 4'd5, 4'd11, 4'd6, 4'd8, 4'd13, 4'd12,
    4'd5, 4'd12, 4'd13, 4'd14, 4'd11, 4'd8, 4'd5, 4'd6,
    4'd8, 4'd9, 4'd9, 4'd11, 4'd13, 4'd15, 4'd15, 4'd5,
    4'd7, 4'd7, 4'd8, 4'd11, 4'd14, 4'd14, 4'd12, 4'd6,
    4'd9, 4'd13, 4'd15, 4'd7, 4'd12, 4'd8, 4'd9, 4'd11,
    4'd7, 4'd7, 4'd12, 4'd7, 4'd6, 4'd15, 4'd13, 4'd11,
    4'd9, 4'd7, 4'd15, 4'd11, 4'd8, 4'd6, 4'd6, 4'd14,
    4'd12, 4'd13, 4'd5, 4'd14, 4'd13, 4'd13, 4'd7, 4'd5,
    4'd15, 4'd5, 4'd8, 4'd11, 4'd14, 4'd14, 4'd6, 4'd14,
    4'd6, 4'd9, 4'd12, 4'd9, 4'd12, 4'd5, 4'd15, 4'd8,
    4'd8, 4'd5, 4'd12, 4'd9, 4'd12, 4'd5, 4'd14, 4'd6,
    4'd8, 4'd13, 4'd6, 4'd5, 4'd15, 4'd13, 4'd11, 4'd11
  };

  // Additive constant for one group of 16 rounds; groups 5 to 9 belong to the right line.
  function automatic logic [31:0] add_const(input logic [3:0] grp);
    logic [31:0] k;
    unique case (grp)
      4'd1:    k = 32'h5a827999;
      4'd2:    k = 32'h6ed9eba1;
      4'd3:    k = 32'h8f1bbcdc;
      4'd4:    k = 32'ha953fd4e;
      4'd5:    k = 32'h50a28be6;
      4'd6:    k = 32'h5c4dd124;
      4'd7:    k = 32'h6d703ef3;
      4'd8:    k = 32'h7a6d76e9;
      default: k = 32'h00000000;
    endcase
    return k;
  endfunction

  function automatic logic [31:0] bool_fn(input logic [2:0] grp, input logic [31:0] x,
                                          input logic [31:0] y, input logic [31:0] z);
    logic [31:0] f;
    unique case (grp)
      3'd0:    f = x ^ y ^ z;
      3'd1:    f = (x & y) | (~x & z);
      3'd2:    f = (x | ~y) ^ z;
      3'd3:    f = (x & z) | (y & ~z);
      default: f = x ^ (y | ~z);
    endcase
    return f;
  endfunction

  function automatic logic [31:0] rotl(input logic [31:0] x, input logic [3:0] n);
    logic [63:0] dbl;
    dbl = {x, x} << n;
    return dbl[63:32];
  endfunction

  function automatic line_t line_round(input line_t v, input logic [2:0] grp,
                                       input logic [31:0] k, input logic [31:0] x,
                                       input logic [3:0] s);
    logic [31:0] t;
    line_t r;
    t   = bool_fn(grp, v.b, v.c, v.d) + k + v.a + x;
    t   = rotl(t, s) + v.e;
    r.a = v.e;
    r.e = v.d;
    r.d = rotl(v.c, 4'd10);
    r.c = v.b;
    r.b = t;
    return r;
  endfunction

endpackage

// ===== sv/rmd160_ram.sv =====
// Generic RAM: one write port and two read ports with registered read data.
// No dependencies.
module rmd160_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_a_i,
  input  logic [$clog2(Depth)-1:0] raddr_b_i,
  output logic [Width-1:0]         rdata_a_o,
  output logic [Width-1:0]         rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_a_q;
  logic [Width-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_q <= mem_q[raddr_a_i];
    rdata_b_q <= mem_q[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

// ===== sv/ripemd160_hash.sv =====
// RIPEMD-160 hash top level: word buffer, padding sequencer, round logic for both lines.
// Depends on rmd160_pkg, rmd160_ram and ripemd160_hash_assert.svh.
//
//   channel | handshake               | payload
//   --------+-------------------------+-------------------------------------------
//   in      | in_valid_i / in_stall_o | message_word_i, byte_count_i, last_word_i
//   out     | out_valid_o/out_stall_i | digest_word_o, word_index_o, digest_last_o
//
// A word that does not fill the buffer is only written to it; the word that fills it starts
// a block: read prefetch, 80 rounds of both lines side by side in separate round logic, fold.
// A last word adds the pad words and, where needed, an extra block, then 5 digest words.
// Reset is asynchronous and loads the initial chaining value; no clearing pass.
// in_stall_o is high from the cycle after a buffer-filling or last word until the block
// is idle again; a stalled digest word holds until taken.
`include "ripemd160_hash_assert.svh"

module ripemd160_hash
  import rmd160_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] message_word_i,
  input  logic [2:0]  byte_count_i,
  input  logic        last_word_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        digest_last_o
);

  state_e      state_q, state_d;
  logic [3:0]  pos_q;
  logic [63:0] len_q;
  logic [31:0] chain_q [ChainN];
  line_t       left_q, right_q;
  logic [6:0]  rnd_q;
  logic        need80_q, final_q, pad_q;
  logic [2:0]  oidx_q;

  logic        in_acc, out_acc;
  logic [2:0]  nb;
  logic [31:0] mask, marker, wdata;
  logic        we;
  logic [6:0]  rd_rnd;
  logic [7:0]  rd_idx_r, cur_idx_r;
  logic [31:0] x_left, x_right;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;

  // Effective byte count: full unless last, clamped to four.
  always_comb begin
    if (!last_word_i || byte_count_i > 3'd4) begin
      nb = 3'd4;
    end else begin
      nb = byte_count_i;
    end
    unique case (nb)
      3'd0:    mask = 32'h00000000;
      3'd1:    mask = 32'h000000ff;
      3'd2:    mask = 32'h0000ffff;
      3'd3:    mask = 32'h00ffffff;
      default: mask = 32'hffffffff;
    endcase
    marker = (message_word_i & mask) | (32'h80 << {nb[1:0], 3'b000});
  end

  // Buffer write data: the input word, or a pad word with the bit length at the end.
  always_comb begin
    we    = 1'b0;
    wdata = 32'h0;
    if (state_q == ST_IDLE) begin
      we    = in_acc;
      wdata = (last_word_i && nb != 3'd4) ? marker : message_word_i;
    end else if (state_q == ST_PAD) begin
      we = 1'b1;
      priority if (need80_q) begin
        wdata = 32'h80;
      end else if (final_q && pos_q == 4'd14) begin
        wdata = {len_q[28:0], 3'b000};
      end else if (final_q && pos_q == 4'd15) begin
        wdata = len_q[60:29];
      end else begin
        wdata = 32'h0;
      end
    end
  end

  // The buffer is read one round ahead of the round unit.
  assign rd_rnd    = (state_q == ST_ROUND && rnd_q != 7'd79) ? rnd_q + 7'd1 : 7'd0;
  assign rd_idx_r  = {1'b0, rd_rnd} + 8'd80;
  assign cur_idx_r = {1'b0, rnd_q} + 8'd80;

  rmd160_ram #(
    .Width (WordW),
    .Depth (BufDepth)
  ) u_buf (
    .clk_i     (clk_i),
    .we_i      (we),
    .waddr_i   (pos_q),
    .wdata_i   (wdata),
    .raddr_a_i (WORD_SEL[rd_rnd]),
    .raddr_b_i (WORD_SEL[rd_idx_r]),
    .rdata_a_o (x_left),
    .rdata_b_o (x_right)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (pos_q == 4'd15) begin
            state_d = ST_PREP;
          end else if (last_word_i) begin
            state_d = ST_PAD;
          end
        end
      end
      ST_PAD:   state_d = (pos_q == 4'd15) ? ST_PREP : ST_PAD;
      ST_PREP:  state_d = ST_ROUND;
      ST_ROUND: state_d = (rnd_q == 7'd79) ? ST_FOLD : ST_ROUND;
      ST_FOLD: begin
        priority if (final_q) begin
          state_d = ST_OUT;
        end else if (pad_q) begin
          state_d = ST_PAD;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_OUT: begin
        if (out_acc && oidx_q == 3'd4) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= 4'd0;
      len_q    <= 64'd0;
      rnd_q    <= 7'd0;
      need80_q <= 1'b0;
      final_q  <= 1'b0;
      pad_q    <= 1'b0;
      oidx_q   <= 3'd0;
      for (int i = 0; i < ChainN; i++) begin
        chain_q[i] <= IV[i];
      end
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            pos_q <= pos_q + 4'd1;
            len_q <= len_q + {61'd0, nb};
            if (last_word_i) begin
              pad_q    <= 1'b1;
              need80_q <= (nb == 3'd4);
              if (nb != 3'd4) begin
                final_q <= (pos_q <= 4'd13);
              end
            end
          end
        end
        ST_PAD: begin
          pos_q <= pos_q + 4'd1;
          if (need80_q) begin
            need80_q <= 1'b0;
            final_q  <= (pos_q <= 4'd13);
          end
        end
        ST_PREP: begin
          rnd_q <= 7'd0;
        end
        ST_ROUND: begin
          rnd_q <= (rnd_q == 7'd79) ? 7'd0 : rnd_q + 7'd1;
        end
        ST_FOLD: begin
          chain_q[0] <= chain_q[1] + left_q.c + right_q.d;
          chain_q[1] <= chain_q[2] + left_q.d + right_q.e;
          chain_q[2] <= chain_q[3] + left_q.e + right_q.a;
          chain_q[3] <= chain_q[4] + left_q.a + right_q.b;
          chain_q[4] <= chain_q[0] + left_q.b + right_q.c;
          oidx_q     <= 3'd0;
          // A block that only held the pad byte is followed by the length block.
          if (!final_q && pad_q && !need80_q) begin
            final_q <= 1'b1;
          end
        end
        ST_OUT: begin
          if (out_acc) begin
            oidx_q <= oidx_q + 3'd1;
            if (oidx_q == 3'd4) begin
              len_q   <= 64'd0;
              pad_q   <= 1'b0;
              final_q <= 1'b0;
              for (int i = 0; i < ChainN; i++) begin
                chain_q[i] <= IV[i];
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Working lines of both halves; one round of each per cycle.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_PREP) begin
      left_q  <= '{a: chain_q[0], b: chain_q[1], c: chain_q[2], d: chain_q[3], e: chain_q[4]};
      right_q <= '{a: chain_q[0], b: chain_q[1], c: chain_q[2], d: chain_q[3], e: chain_q[4]};
    end else if (state_q == ST_ROUND) begin
      left_q  <= line_round(left_q, rnd_q[6:4], add_const({1'b0, rnd_q[6:4]}),
                            x_left, ROT_AMT[rnd_q]);
      right_q <= line_round(right_q, 3'd4 - rnd_q[6:4], add_const(4'd5 + {1'b0, rnd_q[6:4]}),
                            x_right, ROT_AMT[cur_idx_r]);
    end
  end

  assign in_stall_o    = (state_q != ST_IDLE);
  assign out_valid_o   = (state_q == ST_OUT);
  assign digest_word_o = chain_q[oidx_q];
  assign word_index_o  = oidx_q;
  assign digest_last_o = (oidx_q == 3'd4);

  `RMD_ASSERT(a_rnd_range, rnd_q <= 7'd79)
  `RMD_ASSERT(a_prep_full, (state_q == ST_PREP) |-> (pos_q == 4'd0))
  `RMD_ASSERT(a_out_empty, (state_q == ST_OUT) |-> (pos_q == 4'd0 && !need80_q))
  `RMD_ASSERT_NEXT(a_done_clear, out_acc && oidx_q == 3'd4,
                   state_q == ST_IDLE && len_q == 64'd0 && !final_q)

endmodule
